>>> sv/mfp_pkg.sv
package mfp_pkg;

  localparam logic [7:0]  HDR_HI          = 8'hFE;
  localparam logic [7:0]  HDR_LO          = 8'hFF;
  localparam logic [31:0] FIXED_PART      = 32'd4;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd8192;

  typedef enum logic [2:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_LEN,
    PH_CMD,
    PH_SENDER,
    PH_PAYLOAD,
    PH_SUM
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD_SUM = 2'd2,
    KIND_LEN_ERR = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [15:0] command;
    logic [15:0] sender_id;
    logic        last;
  } result_t;

endpackage

>>> sv/mfp_in_reg.sv
module mfp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       space_i,
  output logic       fire_o,
  output logic [7:0] byte_o
);
  import mfp_pkg::*;

  logic       valid_q;
  logic       valid_d;
  logic [7:0] byte_q;

  // The held byte moves on whenever the result register has room.
  assign fire_o     = valid_q && space_i;
  assign in_ready_o = !valid_q || space_i;
  assign byte_o     = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

>>> sv/mfp_core.sv
module mfp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output mfp_pkg::result_t res_o
);
  import mfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  fcnt_q, fcnt_d;
  logic [23:0] len_q, len_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] snd_q, snd_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  rx_hi_q, rx_hi_d;
  logic [15:0] max_q;

  logic [31:0] full_len;
  logic [31:0] full_m4;
  logic [16:0] len_limit;
  logic        len_err;
  logic [15:0] rem_dec;
  logic [15:0] rx_sum;

  assign full_len  = {len_q, byte_i};
  assign full_m4   = full_len - FIXED_PART;
  assign len_limit = {1'b0, max_q} + 17'd4;
  // Too short, or payload count beyond the configured maximum.
  assign len_err   = (full_len < FIXED_PART) || (full_len > {15'd0, len_limit});
  assign rem_dec   = (rem_q != 16'd0) ? (rem_q - 16'd1) : rem_q;
  assign rx_sum    = {rx_hi_q, byte_i};

  // Next state and frame registers.
  always_comb begin
    phase_d = phase_q;
    fcnt_d  = fcnt_q;
    len_d   = len_q;
    rem_d   = rem_q;
    cmd_d   = cmd_q;
    snd_d   = snd_q;
    sum_d   = sum_q;
    rx_hi_d = rx_hi_q;
    if (fire_i) begin
      unique case (phase_q)
        PH_HUNT0: begin
          if (byte_i == HDR_HI) begin
            phase_d = PH_HUNT1;
          end
        end
        PH_HUNT1: begin
          if (byte_i == HDR_LO) begin
            phase_d = PH_LEN;
            fcnt_d  = 2'd0;
          end else if (byte_i != HDR_HI) begin
            phase_d = PH_HUNT0;
          end
        end
        PH_LEN: begin
          len_d = full_len[23:0];
          if (fcnt_q != 2'd3) begin
            fcnt_d = fcnt_q + 2'd1;
          end else begin
            fcnt_d = 2'd0;
            if (len_err) begin
              phase_d = PH_HUNT0;
            end else begin
              rem_d   = full_m4[15:0];
              sum_d   = 16'd0;
              phase_d = PH_CMD;
            end
          end
        end
        PH_CMD: begin
          cmd_d = {cmd_q[7:0], byte_i};
          if (fcnt_q == 2'd0) begin
            fcnt_d = 2'd1;
          end else begin
            fcnt_d  = 2'd0;
            phase_d = PH_SENDER;
          end
        end
        PH_SENDER: begin
          snd_d = {snd_q[7:0], byte_i};
          if (fcnt_q == 2'd0) begin
            fcnt_d = 2'd1;
          end else begin
            fcnt_d  = 2'd0;
            phase_d = (rem_q == 16'd0) ? PH_SUM : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_d = sum_q + {8'd0, byte_i};
          rem_d = rem_dec;
          if (rem_dec == 16'd0) begin
            phase_d = PH_SUM;
            fcnt_d  = 2'd0;
          end
        end
        PH_SUM: begin
          if (fcnt_q == 2'd0) begin
            rx_hi_d = byte_i;
            fcnt_d  = 2'd1;
          end else begin
            fcnt_d  = 2'd0;
            phase_d = PH_HUNT0;
          end
        end
        default: begin
          phase_d = PH_HUNT0;
          fcnt_d  = 2'd0;
        end
      endcase
    end
  end

  // Result for the byte now leaving the input register.
  always_comb begin
    res_valid_o        = 1'b0;
    res_o.kind         = KIND_PAYLOAD;
    res_o.payload_byte = 8'd0;
    res_o.command      = cmd_q;
    res_o.sender_id    = snd_q;
    res_o.last         = 1'b0;
    unique case (phase_q)
      PH_LEN: begin
        if (fcnt_q == 2'd3 && len_err) begin
          res_valid_o     = fire_i;
          res_o.kind      = KIND_LEN_ERR;
          res_o.command   = 16'd0;
          res_o.sender_id = 16'd0;
          res_o.last      = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        res_valid_o        = fire_i;
        res_o.payload_byte = byte_i;
      end
      PH_SUM: begin
        if (fcnt_q != 2'd0) begin
          res_valid_o = fire_i;
          res_o.kind  = (rx_sum == sum_q) ? KIND_GOOD : KIND_BAD_SUM;
          res_o.last  = 1'b1;
        end
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT0;
      fcnt_q  <= 2'd0;
      len_q   <= 24'd0;
      rem_q   <= 16'd0;
      cmd_q   <= 16'd0;
      snd_q   <= 16'd0;
      sum_q   <= 16'd0;
      rx_hi_q <= 8'd0;
      max_q   <= MAX_PAYLOAD_RST;
    end else begin
      phase_q <= phase_d;
      fcnt_q  <= fcnt_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      cmd_q   <= cmd_d;
      snd_q   <= snd_d;
      sum_q   <= sum_d;
      rx_hi_q <= rx_hi_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

endmodule

>>> sv/mfp_out_reg.sv
module mfp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mfp_pkg::result_t res_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mfp_pkg::result_t res_o
);
  import mfp_pkg::*;

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> sv/message_frame_parser.sv
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_ready_o   in_byte_i
// result    out        out_valid_o/out_ready_i kind_o payload_byte_o command_o
//                                              sender_id_o last_o
// config    in         cfg_we_i                cfg_wdata_i (max_payload)
//
// One input byte is taken every cycle while the result channel is not stalled.
// A byte transferred in waits in the input register; the frame state logic
// between the input register and the result register then produces its
// result, if any, which is registered when the result register has room.
// Reset is asynchronous and active low; it returns the parser to hunting for a
// header and restores max_payload to 8192.
// A stalled result holds the pipeline; the input register keeps one byte.
module message_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] command_o,
  output logic [15:0] sender_id_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import mfp_pkg::*;

  // The byte in the input register is consumed as soon as the result
  // register has room, so bytes stream through without gaps.
  logic       space;
  logic       fire;
  logic [7:0] cur_byte;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  mfp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .space_i    (space),
    .fire_o     (fire),
    .byte_o     (cur_byte)
  );

  // The core holds the frame state and the configured maximum. Bytes that
  // produce no result (header, length unless it is in error, command, sender
  // and the first checksum byte) only update state.
  mfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .byte_i      (cur_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign kind_o         = out_res.kind;
  assign payload_byte_o = out_res.payload_byte;
  assign command_o      = out_res.command;
  assign sender_id_o    = out_res.sender_id;
  assign last_o         = out_res.last;

endmodule

>>> sv/mfp_checker.sv
module mfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  in_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  payload_byte_o,
  input logic [15:0] command_o,
  input logic [15:0] sender_id_o,
  input logic        last_o
);
  import mfp_pkg::*;

  // A waiting input byte stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_byte_i))
    else $error("waiting input byte changed");

  // A stalled result must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(payload_byte_o) && $stable(command_o) && $stable(sender_id_o) &&
    $stable(last_o))
    else $error("stalled result changed");

  // Only frame-closing results carry last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o != KIND_PAYLOAD)))
    else $error("last does not match kind");

  // Payload data is zero on every non-payload result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_PAYLOAD) |-> (payload_byte_o == 8'd0))
    else $error("payload byte set on end result");

  // A length error comes before command and sender are known.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_LEN_ERR) |->
    (command_o == 16'd0) && (sender_id_o == 16'd0))
    else $error("length error carries frame fields");

endmodule

bind message_frame_parser mfp_checker u_mfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .in_byte_i      (in_byte_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .payload_byte_o (payload_byte_o),
  .command_o      (command_o),
  .sender_id_o    (sender_id_o),
  .last_o         (last_o)
);
